// ----- rtl/bpa_pkg.sv -----
// Shared types and constants of the bitmap page allocator
`default_nettype none

package bpa_pkg;

   localparam int ADDR_W          = 32;
   localparam int WORD_W          = 32;
   localparam int BIT_POS_W       = 5;
   localparam int PAGE_SHIFT      = 12;
   localparam int PAGE_NUM_W      = ADDR_W - PAGE_SHIFT;
   localparam int STATUS_W        = 3;
   localparam int WORDS_IN_USE_W  = 11;
   localparam int CSR_INDEX_W     = 1;
   localparam int CSR_DATA_W      = 32;

   localparam logic [ADDR_W-1:0]         BASE_ADDRESS_RESET = '0;
   localparam logic [WORDS_IN_USE_W-1:0] WORDS_IN_USE_RESET = 11'd1024;

   // register indexes of the configuration port
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BASE_ADDRESS = 1'b0,
      CSR_WORDS_IN_USE = 1'b1
   } csr_index_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK           = 3'd0,
      STATUS_NO_FREE_PAGE = 3'd1,
      STATUS_MISALIGNED   = 3'd2,
      STATUS_OUT_OF_RANGE = 3'd3,
      STATUS_ALREADY_FREE = 3'd4
   } status_type;

   // operation of the shared address adder
   typedef enum logic {
      ADDR_MODE_PAGE   = 1'b0,
      ADDR_MODE_OFFSET = 1'b1
   } addr_mode_type;

   // outcome of looking at one bitmap word
   typedef struct packed {
      logic                 full;
      logic [BIT_POS_W-1:0] pos;
      logic [WORD_W-1:0]    word_set;
   } bit_find_type;

endpackage

`default_nettype wire

// ----- rtl/bpa_bit_finder.sv -----
// Lowest clear bit search over one bitmap word
`default_nettype none

module bpa_bit_finder (
   input  wire logic [bpa_pkg::WORD_W-1:0] word,
   output bpa_pkg::bit_find_type           result
);

   logic [bpa_pkg::WORD_W-1:0]    word_inc;
   logic [bpa_pkg::WORD_W-1:0]    lowest_clear;
   logic [bpa_pkg::BIT_POS_W-1:0] pos;

   // word + 1 carries through the trailing ones into the lowest clear bit
   assign word_inc     = word + bpa_pkg::WORD_W'(1);
   assign lowest_clear = ~word & word_inc;

   // encode the one-hot lowest clear bit
   always_comb begin
      pos = '0;
      for (int i = 0; i < bpa_pkg::WORD_W; i++) begin
         if (lowest_clear[i]) begin
            pos = pos | bpa_pkg::BIT_POS_W'(i);
         end
      end
   end

   assign result.full     = &word;
   assign result.pos      = pos;
   assign result.word_set = word | word_inc;

endmodule

`default_nettype wire

// ----- rtl/bpa_addr_unit.sv -----
// Shared address adder: page number to address, or address to offset
`default_nettype none

module bpa_addr_unit (
   input  wire bpa_pkg::addr_mode_type            mode,
   input  wire logic [bpa_pkg::ADDR_W-1:0]        base_address,
   input  wire logic [bpa_pkg::PAGE_NUM_W-1:0]    page_number,
   input  wire logic [bpa_pkg::ADDR_W-1:0]        page_address,
   output logic      [bpa_pkg::ADDR_W-1:0]        sum
);

   logic [bpa_pkg::ADDR_W-1:0] operand_a;
   logic [bpa_pkg::ADDR_W-1:0] operand_b;
   logic                       carry_in;

   // operand selection: base + page * 4096, or address - base
   always_comb begin
      unique case (mode)
         bpa_pkg::ADDR_MODE_PAGE: begin
            operand_a = base_address;
            operand_b = {page_number, bpa_pkg::PAGE_SHIFT'(0)};
            carry_in  = 1'b0;
         end
         bpa_pkg::ADDR_MODE_OFFSET: begin
            operand_a = page_address;
            operand_b = ~base_address;
            carry_in  = 1'b1;
         end
         default: begin
            operand_a = base_address;
            operand_b = '0;
            carry_in  = 1'b0;
         end
      endcase
   end

   // one 32-bit add, wraps modulo 2^32
   assign sum = operand_a + operand_b + bpa_pkg::ADDR_W'(carry_in);

endmodule

`default_nettype wire

// ----- rtl/bpa_word_mem.sv -----
// Bitmap word memory with a fill count standing in for the reset clear
`default_nettype none

module bpa_word_mem #(
   parameter  int MAP_WORDS   = 1024,
   localparam int WORD_ADDR_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         rd_en,
   input  wire logic [WORD_ADDR_W-1:0]       rd_addr,
   output logic      [bpa_pkg::WORD_W-1:0]   rd_data,
   input  wire logic                         wr_en,
   input  wire logic [WORD_ADDR_W-1:0]       wr_addr,
   input  wire logic [bpa_pkg::WORD_W-1:0]   wr_data
);

   localparam int COUNT_W = $clog2(MAP_WORDS + 1);

   logic [bpa_pkg::WORD_W-1:0] mem [MAP_WORDS];
   logic [bpa_pkg::WORD_W-1:0] data_ff;
   logic                       hit_ff;
   logic [COUNT_W-1:0]         fill_ff;

   // words are written only as a prefix, so entries at or above the fill
   // count have never been written since reset and read as all free
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (wr_en && (COUNT_W'(wr_addr) >= fill_ff)) begin
         fill_ff <= COUNT_W'(wr_addr) + COUNT_W'(1);
      end
   end

   // memory write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_ff <= mem[rd_addr];
         hit_ff  <= COUNT_W'(rd_addr) < fill_ff;
      end
   end

   assign rd_data = hit_ff ? data_ff : '0;

endmodule

`default_nettype wire

// ----- rtl/bitmap_page_allocator_unit.sv -----
// Top level of the bitmap page allocator: sequencer, registers and ports
//
// Keeps one bit per 4 KiB page in MAP_WORDS words of 32 bits held in a
// single-port-read memory; a set bit is a taken page, and every page is free
// after reset with no clearing pass. An allocate request reads the words
// from word 0 upward, one per cycle, and takes the lowest clear bit of the
// first word that is not full. When no word in use has a clear bit, the
// result is no-free-page. A free request goes through offset and alignment
// check, range check and word read, then bit check and update; a misaligned
// free ends after the offset step and an out of range free after the range
// check. The memory read port and the one shared 32-bit address adder serve
// both kinds of request. Only one request is in flight; req_stall is high
// from acceptance until the result is loaded into the output register.
// The user must write the registers (base_address, words_in_use) only while
// the block is idle; the block itself does not enforce this.
`default_nettype none

module bitmap_page_allocator_unit #(
   parameter int MAP_WORDS = 1024
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_op,
   input  wire logic [bpa_pkg::ADDR_W-1:0]          req_page_address,
   // result channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic      [bpa_pkg::ADDR_W-1:0]          rsp_result_address,
   output logic      [bpa_pkg::STATUS_W-1:0]        rsp_status,
   // configuration port
   input  wire logic                                csr_write_enable,
   input  wire logic [bpa_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [bpa_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   localparam int WORD_ADDR_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int COUNT_W     = $clog2(MAP_WORDS + 1);
   localparam int WIDE_W      = (COUNT_W > bpa_pkg::WORDS_IN_USE_W) ?
                                COUNT_W : bpa_pkg::WORDS_IN_USE_W;
   localparam int LIMIT_W     = (COUNT_W + bpa_pkg::BIT_POS_W > bpa_pkg::PAGE_NUM_W) ?
                                COUNT_W + bpa_pkg::BIT_POS_W : bpa_pkg::PAGE_NUM_W;

   localparam logic OP_ALLOC = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_ALLOC_ADDR,
      ST_FREE_OFFSET,
      ST_FREE_RANGE,
      ST_FREE_BIT,
      ST_RESULT
   } state_type;

   state_type                                 state_ff,  state_in;
   logic [bpa_pkg::ADDR_W-1:0]                base_ff,   base_in;
   logic [bpa_pkg::WORDS_IN_USE_W-1:0]        words_ff,  words_in;
   logic [bpa_pkg::ADDR_W-1:0]                addr_ff,   addr_in;
   logic [WORD_ADDR_W-1:0]                    idx_ff,    idx_in;
   logic [bpa_pkg::PAGE_NUM_W-1:0]            page_ff,   page_in;
   logic [bpa_pkg::ADDR_W-1:0]                res_addr_ff,   res_addr_in;
   bpa_pkg::status_type                       res_status_ff, res_status_in;
   logic                                      rsp_valid_ff,  rsp_valid_in;
   logic [bpa_pkg::ADDR_W-1:0]                rsp_addr_ff,   rsp_addr_in;
   bpa_pkg::status_type                       rsp_status_ff, rsp_status_in;

   logic                                      req_accept;
   logic [COUNT_W-1:0]                        active_words;
   logic [LIMIT_W-1:0]                        page_limit;
   logic                                      rd_en;
   logic [WORD_ADDR_W-1:0]                    rd_addr;
   logic [bpa_pkg::WORD_W-1:0]                rd_data;
   logic                                      wr_en;
   logic [WORD_ADDR_W-1:0]                    wr_addr;
   logic [bpa_pkg::WORD_W-1:0]                wr_data;
   bpa_pkg::bit_find_type                     find;
   bpa_pkg::addr_mode_type                    addr_mode;
   logic [bpa_pkg::ADDR_W-1:0]                addr_sum;
   logic [WORD_ADDR_W+bpa_pkg::BIT_POS_W-1:0] found_page;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // effective word count: words in use, capped at the map size
   assign active_words = (WIDE_W'(words_ff) > WIDE_W'(MAP_WORDS)) ?
                         COUNT_W'(MAP_WORDS) : COUNT_W'(words_ff);
   assign page_limit   = LIMIT_W'({active_words, bpa_pkg::BIT_POS_W'(0)});

   assign found_page = {idx_ff, find.pos};
   assign addr_mode  = (state_ff == ST_ALLOC_ADDR) ? bpa_pkg::ADDR_MODE_PAGE :
                                                     bpa_pkg::ADDR_MODE_OFFSET;

   bpa_word_mem #(
      .MAP_WORDS (MAP_WORDS)
   ) u_word_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   bpa_bit_finder u_bit_finder (
      .word   (rd_data),
      .result (find)
   );

   bpa_addr_unit u_addr_unit (
      .mode         (addr_mode),
      .base_address (base_ff),
      .page_number  (page_ff),
      .page_address (addr_ff),
      .sum          (addr_sum)
   );

   // sequencer and next-state logic
   always_comb begin
      state_in      = state_ff;
      base_in       = base_ff;
      words_in      = words_ff;
      addr_in       = addr_ff;
      idx_in        = idx_ff;
      page_in       = page_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = find.word_set;

      // register writes
      if (csr_write_enable) begin
         unique case (bpa_pkg::csr_index_type'(csr_index))
            bpa_pkg::CSR_BASE_ADDRESS: base_in  = csr_write_data;
            bpa_pkg::CSR_WORDS_IN_USE: words_in =
               csr_write_data[bpa_pkg::WORDS_IN_USE_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               addr_in = req_page_address;
               idx_in  = '0;
               if (req_op == OP_ALLOC) begin
                  // word 0 is read at acceptance
                  rd_en = 1'b1;
                  if (active_words == '0) begin
                     res_addr_in   = '0;
                     res_status_in = bpa_pkg::STATUS_NO_FREE_PAGE;
                     state_in      = ST_RESULT;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end else begin
                  state_in = ST_FREE_OFFSET;
               end
            end
         end

         // check word idx while reading word idx + 1
         ST_SCAN: begin
            if (!find.full) begin
               wr_en    = 1'b1;
               page_in  = bpa_pkg::PAGE_NUM_W'(found_page);
               state_in = ST_ALLOC_ADDR;
            end else if (COUNT_W'(idx_ff) + COUNT_W'(1) == active_words) begin
               res_addr_in   = '0;
               res_status_in = bpa_pkg::STATUS_NO_FREE_PAGE;
               state_in      = ST_RESULT;
            end else begin
               rd_en   = 1'b1;
               rd_addr = idx_ff + WORD_ADDR_W'(1);
               idx_in  = idx_ff + WORD_ADDR_W'(1);
            end
         end

         ST_ALLOC_ADDR: begin
            res_addr_in   = addr_sum;
            res_status_in = bpa_pkg::STATUS_OK;
            state_in      = ST_RESULT;
         end

         // offset from the base, alignment check first
         ST_FREE_OFFSET: begin
            page_in = addr_sum[bpa_pkg::ADDR_W-1:bpa_pkg::PAGE_SHIFT];
            if (addr_sum[bpa_pkg::PAGE_SHIFT-1:0] != '0) begin
               res_addr_in   = '0;
               res_status_in = bpa_pkg::STATUS_MISALIGNED;
               state_in      = ST_RESULT;
            end else begin
               state_in = ST_FREE_RANGE;
            end
         end

         ST_FREE_RANGE: begin
            if (LIMIT_W'(page_ff) >= page_limit) begin
               res_addr_in   = '0;
               res_status_in = bpa_pkg::STATUS_OUT_OF_RANGE;
               state_in      = ST_RESULT;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = page_ff[WORD_ADDR_W+bpa_pkg::BIT_POS_W-1:bpa_pkg::BIT_POS_W];
               idx_in   = page_ff[WORD_ADDR_W+bpa_pkg::BIT_POS_W-1:bpa_pkg::BIT_POS_W];
               state_in = ST_FREE_BIT;
            end
         end

         // clear the page bit, or report it already free
         ST_FREE_BIT: begin
            res_addr_in = '0;
            if (!rd_data[page_ff[bpa_pkg::BIT_POS_W-1:0]]) begin
               res_status_in = bpa_pkg::STATUS_ALREADY_FREE;
            end else begin
               wr_en         = 1'b1;
               wr_data       = rd_data & ~(bpa_pkg::WORD_W'(1) <<
                                           page_ff[bpa_pkg::BIT_POS_W-1:0]);
               res_status_in = bpa_pkg::STATUS_OK;
            end
            state_in = ST_RESULT;
         end

         // hand the result to the output register once it is free
         ST_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = res_addr_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // state, registers and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         base_ff      <= bpa_pkg::BASE_ADDRESS_RESET;
         words_ff     <= bpa_pkg::WORDS_IN_USE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         words_ff     <= words_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      addr_ff       <= addr_in;
      idx_ff        <= idx_in;
      page_ff       <= page_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_address = rsp_addr_ff;
   assign rsp_status         = rsp_status_ff;

endmodule

`default_nettype wire

// ----- test/bitmap_page_allocator_unit_test.sv -----
// Self-checking testbench for the bitmap page allocator with its page map predictor
package bpa_test_pkg;
   import bpa_pkg::*;

   localparam int   MAP_WORDS   = 1024;
   localparam logic OP_ALLOCATE = 1'b0;
   localparam logic OP_FREE     = 1'b1;

   // one predicted response
   typedef struct {
      logic [ADDR_W-1:0] result_address;
      status_type        status;
   } page_outcome_t;

   // tracks the page map and config, predicts and checks every response
   class page_frame_predictor;
      logic [WORD_W-1:0]         page_map [MAP_WORDS];
      logic [ADDR_W-1:0]         base_address;
      logic [WORDS_IN_USE_W-1:0] words_in_use;
      page_outcome_t             expected_results [$];
      logic [ADDR_W-1:0]         granted_pages [$];
      int                        mismatches;
      int                        checked;
      int                        tally [2][8];

      function new();
         foreach (page_map[i]) page_map[i] = '0;
         foreach (tally[i, j]) tally[i][j] = 0;
         base_address = BASE_ADDRESS_RESET;
         words_in_use = WORDS_IN_USE_RESET;
         mismatches   = 0;
         checked      = 0;
      endfunction

      function void apply_register(csr_index_type index, logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_BASE_ADDRESS: base_address = value;
            CSR_WORDS_IN_USE: words_in_use = value[WORDS_IN_USE_W-1:0];
            default: ;
         endcase
      endfunction

      // word count clipped to the size of the map
      function int unsigned managed_words();
         return (words_in_use > MAP_WORDS) ? MAP_WORDS : int'(words_in_use);
      endfunction

      // work out the response to an accepted request and update the map
      function void note_request(logic op, logic [ADDR_W-1:0] page_address);
         page_outcome_t     outcome;
         int unsigned       words;
         int unsigned       word;
         int unsigned       bit_pos;
         int unsigned       page;
         logic [ADDR_W-1:0] offset;
         bit                found;
         outcome.result_address = '0;
         outcome.status         = STATUS_OK;
         words                  = managed_words();
         found                  = 1'b0;
         if (op == OP_ALLOCATE) begin
            outcome.status = STATUS_NO_FREE_PAGE;
            // first word that is not full, lowest clear bit in it
            for (word = 0; word < words && !found; word++) begin
               if (page_map[word] != '1) begin
                  bit_pos = 0;
                  while (page_map[word][bit_pos]) bit_pos++;
                  page_map[word][bit_pos] = 1'b1;
                  page = word * 32 + bit_pos;
                  outcome.result_address = base_address + (ADDR_W'(page) << PAGE_SHIFT);
                  outcome.status         = STATUS_OK;
                  granted_pages.push_back(outcome.result_address);
                  if (granted_pages.size() > 64) void'(granted_pages.pop_front());
                  found = 1'b1;
               end
            end
         end else begin
            // offset wraps modulo 2^32; alignment is checked before range
            offset = page_address - base_address;
            if (offset[PAGE_SHIFT-1:0] != '0) begin
               outcome.status = STATUS_MISALIGNED;
            end else begin
               page = offset >> PAGE_SHIFT;
               if (page >= words * 32) begin
                  outcome.status = STATUS_OUT_OF_RANGE;
               end else if (!page_map[page / 32][page % 32]) begin
                  outcome.status = STATUS_ALREADY_FREE;
               end else begin
                  page_map[page / 32][page % 32] = 1'b0;
               end
            end
         end
         tally[op][outcome.status]++;
         expected_results.push_back(outcome);
      endfunction

      task report_mismatch(string what);
         mismatches++;
         if (mismatches <= 40) $display("[%0t] mismatch at response %0d: %s", $time, checked, what);
      endtask

      // compare a response with the oldest prediction
      task check_result(logic [ADDR_W-1:0] result_address, logic [STATUS_W-1:0] status);
         page_outcome_t want;
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("response with no request pending: address %h status %0d",
                                      result_address, status));
         end else begin
            want = expected_results.pop_front();
            checked++;
            if (result_address !== want.result_address)
               report_mismatch($sformatf("result_address %h, predicted %h",
                                         result_address, want.result_address));
            if (status !== want.status)
               report_mismatch($sformatf("status %0d, predicted %0d", status, want.status));
         end
      endtask
   endclass
endpackage

module bitmap_page_allocator_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import bpa_pkg::*;
   import bpa_test_pkg::*;

   localparam int WATCHDOG_LIMIT  = 20000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int TAIL_CYCLES     = 64;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic                   req_op;
   logic [ADDR_W-1:0]      req_page_address;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [ADDR_W-1:0]      rsp_result_address;
   logic [STATUS_W-1:0]    rsp_status;
   logic                   csr_write_enable;
   csr_index_type          csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   page_frame_predictor predictor;
   int  send_idle_pct    = 0;
   int  rsp_stall_pct    = 0;
   bit  hold_off_ask     = 1'b0;
   int  hold_off_left    = 0;
   int  quiet_cycles     = 0;
   int  settings_applied = 0;

   bitmap_page_allocator_unit #(.MAP_WORDS(MAP_WORDS)) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_page_address   (req_page_address),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_address (rsp_result_address),
      .rsp_status         (rsp_status),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // response side back-pressure, with an occasional long hold-off
   always @(negedge clock) begin
      if (hold_off_left > 0) begin
         rsp_stall     <= 1'b1;
         hold_off_left <= hold_off_left - 1;
      end else if (hold_off_ask) begin
         hold_off_ask  = 1'b0;
         rsp_stall     <= 1'b1;
         hold_off_left <= HOLD_OFF_CYCLES;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // handshake monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) predictor.note_request(req_op, req_page_address);
         if (rsp_valid && !rsp_stall) predictor.check_result(rsp_result_address, rsp_status);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d responses pending",
                     quiet_cycles, predictor.expected_results.size());
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // offer one request, with random idle cycles first; returns at a falling edge
   task automatic send_request(logic op, logic [ADDR_W-1:0] page_address);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid        <= 1'b0;
         req_op           <= 1'($urandom_range(1));
         req_page_address <= $urandom;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_op           <= op;
      req_page_address <= page_address;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // stop offering and wait for every predicted response
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (predictor.expected_results.size() != 0) @(negedge clock);
   endtask

   task automatic write_register(csr_index_type index, logic [CSR_DATA_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      predictor.apply_register(index, value);
   endtask

   task automatic apply_settings(logic [ADDR_W-1:0] base, logic [WORDS_IN_USE_W-1:0] words);
      wait_for_results();
      write_register(CSR_BASE_ADDRESS, base);
      write_register(CSR_WORDS_IN_USE, CSR_DATA_W'(words));
      settings_applied++;
   endtask

   // allocations and mostly well-formed frees of granted or in-range pages, some bad ones
   function automatic void pick_request(output logic op, output logic [ADDR_W-1:0] page_address);
      int unsigned roll;
      int unsigned span;
      int unsigned page;
      roll         = $urandom_range(99);
      span         = predictor.managed_words() * 32;
      page         = (span == 0) ? $urandom_range(3) : $urandom_range(span - 1);
      op           = OP_FREE;
      page_address = $urandom;
      if (roll < 55) begin
         op = OP_ALLOCATE;
      end else if (roll < 70 && predictor.granted_pages.size() != 0) begin
         page_address =
            predictor.granted_pages[$urandom_range(predictor.granted_pages.size() - 1)];
      end else if (roll < 85) begin
         page_address = predictor.base_address + (ADDR_W'(page) << PAGE_SHIFT);
      end else if (roll < 90) begin
         page_address = predictor.base_address + (ADDR_W'(page) << PAGE_SHIFT)
                        + ADDR_W'($urandom_range(1, 4095));
      end else if (roll < 95) begin
         page_address = predictor.base_address
                        + (ADDR_W'(span + $urandom_range(40)) << PAGE_SHIFT);
      end
   endfunction

   task automatic run_phase(logic [ADDR_W-1:0] base, logic [WORDS_IN_USE_W-1:0] words,
                            int send_pct, int stall_pct, int requests, bit hold);
      logic              op;
      logic [ADDR_W-1:0] page_address;
      int                n;
      apply_settings(base, words);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      if (hold) hold_off_ask = 1'b1;
      for (n = 0; n < requests; n++) begin
         // halfway through, let the block drain completely
         if (n == requests / 2) wait_for_results();
         pick_request(op, page_address);
         send_request(op, page_address);
      end
   endtask

   // edge cases at reset settings, with no words, and with a wrapping base
   task automatic directed_requests();
      send_request(OP_FREE, 32'h0000_0000);
      send_request(OP_ALLOCATE, $urandom);
      send_request(OP_ALLOCATE, $urandom);
      send_request(OP_FREE, 32'h0000_1000);
      send_request(OP_FREE, 32'h0000_1000);
      send_request(OP_FREE, 32'h0000_0800);
      send_request(OP_FREE, 32'hFFFF_FFFF);
      send_request(OP_FREE, 32'h0000_0001);
      send_request(OP_FREE, 32'h0800_0000);
      send_request(OP_FREE, 32'h07FF_F000);
      send_request(OP_FREE, 32'hFFFF_F000);
      send_request(OP_ALLOCATE, 32'hFFFF_FFFF);
      apply_settings(32'h0000_0000, 11'd0);
      send_request(OP_ALLOCATE, $urandom);
      send_request(OP_FREE, 32'h0000_0000);
      apply_settings(32'hFFFF_F000, 11'd1);
      send_request(OP_ALLOCATE, $urandom);
      send_request(OP_FREE, 32'h0000_1000);
      send_request(OP_FREE, 32'hFFFF_F000);
      send_request(OP_ALLOCATE, $urandom);
      send_request(OP_FREE, 32'hFFFF_E000);
   endtask

   // main sequence
   initial begin
      predictor        = new();
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_op           = OP_ALLOCATE;
      req_page_address = '0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_BASE_ADDRESS;
      csr_write_data   = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      directed_requests();

      run_phase(32'h0000_0000,               11'd1,    0,  0,  140, 1'b0);
      run_phase(32'h0004_0000,               11'd2,    51, 0,  140, 1'b0);
      run_phase(32'hFFFE_0000,               11'd3,    0,  51, 140, 1'b0);
      run_phase($urandom & 32'hFFFF_F000,    11'd32,   8,  8,  140, 1'b1);
      run_phase(32'h0000_0000,               11'd0,    0,  0,  40,  1'b0);
      run_phase(32'h0ABC_D123,               11'd2,    8,  8,  100, 1'b0);
      run_phase(32'h1234_5000,               11'd1024, 0,  51, 140, 1'b0);
      run_phase(32'hFFFF_F000,               11'd2047, 51, 0,  100, 1'b1);
      run_phase(32'h0000_0000,               11'd1100, 8,  8,  60,  1'b0);
      run_phase(32'h0000_0000,               11'd1,    0,  0,  60,  1'b0);

      wait_for_results();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (predictor.expected_results.size() != 0)
         predictor.report_mismatch("predicted responses never arrived");

      $display("%0d responses checked over %0d base/word-count settings",
               predictor.checked, settings_applied);
      $display("allocs: %0d granted, %0d map full; frees: %0d ok, %0d misaligned, %0d out of range, %0d double",
               predictor.tally[OP_ALLOCATE][STATUS_OK],
               predictor.tally[OP_ALLOCATE][STATUS_NO_FREE_PAGE],
               predictor.tally[OP_FREE][STATUS_OK],
               predictor.tally[OP_FREE][STATUS_MISALIGNED],
               predictor.tally[OP_FREE][STATUS_OUT_OF_RANGE],
               predictor.tally[OP_FREE][STATUS_ALREADY_FREE]);
      if (predictor.mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
